// ===== hw/rtl/bra_pkg.sv =====
// shared types and constants for the bitmap range allocator
package bra_pkg;

    // store geometry
    localparam int MAP_BITS  = 4096;
    localparam int WORD_BITS = 64;
    localparam int WORDS     = MAP_BITS / WORD_BITS;
    localparam int WADDR_W   = $clog2(WORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);

    // field widths
    localparam int OP_W      = 3;
    localparam int START_W   = 12;
    localparam int LEN_W     = 13;
    localparam int ALOG_W    = 4;
    localparam int STAT_W    = 2;
    localparam int CFG_W     = 13;
    localparam int CFG_RESET = 4096;

    // bit positions, wide enough for an aligned candidate plus one step
    localparam int POS_W     = 18;

    // packed stream words
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_SET        = 3'd0,
        OP_CLEAR      = 3'd1,
        OP_TEST_SET   = 3'd2,
        OP_TEST_CLEAR = 3'd3,
        OP_FIND_CLEAR = 3'd4,
        OP_FIND_SET   = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_PARAM    = 2'd1,
        STAT_MISMATCH = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_CHECK,
        S_FINISH
    } state_t;

    // controls for the shared word unit
    typedef struct packed {
        logic [BIT_W-1:0] lo;
        logic [BIT_W-1:0] hi;
        logic             want;
        logic             set_bits;
    } word_ctl_t;

    // results of the shared word unit
    typedef struct packed {
        logic                 mism;
        logic [BIT_W-1:0]     pos;
        logic [WORD_BITS-1:0] wdata;
    } word_res_t;

    // store access request from the sequencer
    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic [WADDR_W-1:0] addr;
    } mem_req_t;

endpackage

// ===== hw/rtl/bra_ram.sv =====
// generic single-write, single-read ram with registered read data
module bra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/bra_word_unit.sv =====
// shared word unit: window mask, mismatch search and masked update of one word
module bra_word_unit (
    input  logic [bra_pkg::WORD_BITS-1:0] data,
    input  bra_pkg::word_ctl_t            ctl,
    output bra_pkg::word_res_t            res
);

    logic [bra_pkg::WORD_BITS-1:0] mask;
    logic [bra_pkg::WORD_BITS-1:0] mism_vec;

    // bits lo..hi of the word take part
    always_comb
    begin
        mask = ({bra_pkg::WORD_BITS{1'b1}} << ctl.lo)
             & ({bra_pkg::WORD_BITS{1'b1}}
                >> (bra_pkg::BIT_W'(bra_pkg::WORD_BITS - 1) - ctl.hi));
        mism_vec = (ctl.want ? ~data : data) & mask;
    end

    // lowest mismatching bit and the updated word
    always_comb
    begin
        res.pos = '0;
        for (int i = bra_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (mism_vec[i])
            begin
                res.pos = bra_pkg::BIT_W'(i);
            end
        end
        res.mism  = |mism_vec;
        res.wdata = ctl.set_bits ? (data | mask) : (data & ~mask);
    end

endmodule

// ===== hw/rtl/bra_ctrl.sv =====
// request sequencer: decode, word walk, aligned candidate search, result register
module bra_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bra_pkg::CFG_W-1:0]     cfg_size,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bra_pkg::OP_W-1:0]      opcode,
    input  logic [bra_pkg::START_W-1:0]   start_index,
    input  logic [bra_pkg::LEN_W-1:0]     run_length,
    input  logic [bra_pkg::ALOG_W-1:0]    align_log2,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bra_pkg::STAT_W-1:0]    status,
    output logic [bra_pkg::START_W-1:0]   found_index,
    output bra_pkg::mem_req_t             mem_req,
    output bra_pkg::word_ctl_t            word_ctl,
    input  bra_pkg::word_res_t            word_res
);

    bra_pkg::state_t                state_reg, state_next;
    logic [bra_pkg::OP_W-1:0]       op_reg, op_next;
    logic [bra_pkg::START_W-1:0]    start_reg, start_next;
    logic [bra_pkg::LEN_W-1:0]      len_reg, len_next;
    logic [bra_pkg::ALOG_W-1:0]     alog_reg, alog_next;
    logic                           first_reg, first_next;
    logic [bra_pkg::POS_W-1:0]      cand_reg, cand_next;
    logic [bra_pkg::POS_W-1:0]      endm_reg, endm_next;
    logic [bra_pkg::POS_W-1:0]      step_reg, step_next;
    logic [bra_pkg::WADDR_W-1:0]    word_reg, word_next;
    bra_pkg::status_t               status_reg, status_next;
    logic [bra_pkg::START_W-1:0]    found_reg, found_next;
    logic                           m_valid_reg, m_valid_next;
    logic [bra_pkg::STAT_W-1:0]     out_status_reg, out_status_next;
    logic [bra_pkg::START_W-1:0]    out_found_reg, out_found_next;

    logic [bra_pkg::POS_W-1:0]      size_w;
    logic [bra_pkg::POS_W-1:0]      step_w;
    logic [bra_pkg::POS_W-1:0]      s0_w;
    logic [bra_pkg::POS_W-1:0]      first_cand;
    logic [bra_pkg::POS_W-1:0]      endm_calc;
    logic [bra_pkg::POS_W-1:0]      p_abs;
    logic [bra_pkg::POS_W-1:0]      new_cand;
    logic                           is_find;
    logic                           is_test;
    logic                           is_write;
    logic                           op_bad;
    logic                           end_over;
    logic                           cur_last;
    logic                           cand_here;
    logic                           out_load;

    // opcode classes
    always_comb
    begin
        is_find  = (op_reg == bra_pkg::OP_FIND_CLEAR) || (op_reg == bra_pkg::OP_FIND_SET);
        is_test  = (op_reg == bra_pkg::OP_TEST_SET) || (op_reg == bra_pkg::OP_TEST_CLEAR);
        is_write = (op_reg == bra_pkg::OP_SET) || (op_reg == bra_pkg::OP_CLEAR);
        op_bad   = op_reg > bra_pkg::OP_FIND_SET;
    end

    // managed size, aligned search start, run end and window bounds
    always_comb
    begin
        size_w = (bra_pkg::POS_W'(cfg_size) > bra_pkg::POS_W'(bra_pkg::MAP_BITS))
               ? bra_pkg::POS_W'(bra_pkg::MAP_BITS) : bra_pkg::POS_W'(cfg_size);
        step_w = bra_pkg::POS_W'(1) << alog_reg;
        s0_w   = (bra_pkg::POS_W'(start_reg) + step_w - bra_pkg::POS_W'(1))
               & ~(step_w - bra_pkg::POS_W'(1));
        first_cand = is_find ? s0_w : bra_pkg::POS_W'(start_reg);
        endm_calc  = cand_reg + bra_pkg::POS_W'(len_reg) - bra_pkg::POS_W'(1);
        end_over   = endm_calc >= size_w;
        cur_last   = (endm_reg >> bra_pkg::BIT_W) == bra_pkg::POS_W'(word_reg);
        cand_here  = (cand_reg >> bra_pkg::BIT_W) == bra_pkg::POS_W'(word_reg);
        p_abs      = bra_pkg::POS_W'({word_reg, word_res.pos});
        new_cand   = (p_abs + step_reg) & ~(step_reg - bra_pkg::POS_W'(1));
    end

    // shared word unit controls
    always_comb
    begin
        word_ctl.lo       = cand_here ? cand_reg[bra_pkg::BIT_W-1:0] : '0;
        word_ctl.hi       = cur_last ? endm_reg[bra_pkg::BIT_W-1:0] : '1;
        word_ctl.want     = (op_reg == bra_pkg::OP_TEST_SET) || (op_reg == bra_pkg::OP_FIND_SET);
        word_ctl.set_bits = op_reg == bra_pkg::OP_SET;
    end

    assign out_load = !m_valid_reg || m_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bra_pkg::S_IDLE:
            begin
                if (s_valid)
                begin
                    state_next = bra_pkg::S_DECODE;
                end
            end
            bra_pkg::S_DECODE:
            begin
                if ((len_reg == '0) || op_bad)
                begin
                    state_next = bra_pkg::S_FINISH;
                end
                else
                begin
                    state_next = bra_pkg::S_READ;
                end
            end
            bra_pkg::S_READ:
            begin
                if (end_over)
                begin
                    state_next = bra_pkg::S_FINISH;
                end
                else
                begin
                    state_next = bra_pkg::S_CHECK;
                end
            end
            bra_pkg::S_CHECK:
            begin
                priority if ((is_test || is_find) && word_res.mism)
                begin
                    state_next = is_find ? bra_pkg::S_READ : bra_pkg::S_FINISH;
                end
                else if (cur_last)
                begin
                    state_next = bra_pkg::S_FINISH;
                end
                else
                begin
                    state_next = bra_pkg::S_READ;
                end
            end
            bra_pkg::S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = bra_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bra_pkg::S_IDLE;
            end
        endcase
    end

    // datapath updates and store requests
    always_comb
    begin
        op_next         = op_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        alog_next       = alog_reg;
        first_next      = first_reg;
        cand_next       = cand_reg;
        endm_next       = endm_reg;
        step_next       = step_reg;
        word_next       = word_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        s_ready         = 1'b0;
        mem_req.rd_en   = 1'b0;
        mem_req.wr_en   = 1'b0;
        mem_req.addr    = word_reg;
        unique case (state_reg)
            bra_pkg::S_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    op_next    = opcode;
                    start_next = start_index;
                    len_next   = run_length;
                    alog_next  = align_log2;
                end
            end
            bra_pkg::S_DECODE:
            begin
                status_next = bra_pkg::STAT_PARAM;
                found_next  = '0;
                first_next  = 1'b1;
                step_next   = step_w;
                cand_next   = first_cand;
                word_next   = first_cand[bra_pkg::BIT_W +: bra_pkg::WADDR_W];
            end
            bra_pkg::S_READ:
            begin
                endm_next  = endm_calc;
                first_next = 1'b0;
                if (end_over)
                begin
                    status_next = first_reg ? bra_pkg::STAT_PARAM : bra_pkg::STAT_NOTFOUND;
                end
                else
                begin
                    mem_req.rd_en = 1'b1;
                end
            end
            bra_pkg::S_CHECK:
            begin
                mem_req.wr_en = is_write;
                priority if ((is_test || is_find) && word_res.mism)
                begin
                    if (is_find)
                    begin
                        cand_next = new_cand;
                        word_next = new_cand[bra_pkg::BIT_W +: bra_pkg::WADDR_W];
                    end
                    else
                    begin
                        status_next = bra_pkg::STAT_MISMATCH;
                    end
                end
                else if (cur_last)
                begin
                    status_next = bra_pkg::STAT_OK;
                    found_next  = is_find ? cand_reg[bra_pkg::START_W-1:0] : '0;
                end
                else
                begin
                    word_next = word_reg + bra_pkg::WADDR_W'(1);
                end
            end
            bra_pkg::S_FINISH:
            begin
                if (out_load)
                begin
                    m_valid_next    = 1'b1;
                    out_status_next = status_reg;
                    out_found_next  = found_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bra_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        start_reg      <= start_next;
        len_reg        <= len_next;
        alog_reg       <= alog_next;
        first_reg      <= first_next;
        cand_reg       <= cand_next;
        endm_reg       <= endm_next;
        step_reg       <= step_next;
        word_reg       <= word_next;
        status_reg     <= status_next;
        found_reg      <= found_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
    end

    assign m_valid     = m_valid_reg;
    assign status      = out_status_reg;
    assign found_index = out_found_reg;

endmodule

// ===== hw/rtl/bitmap_range_allocator.sv =====
// bitmap range allocator: set, clear, test and aligned search over a bit store
// a request passes a decode state, a read and a check state per store word visited, and a finish
// state that posts the result; a set, clear or test walks the words of its run once,
// and the sequencer then returns to idle, where it takes the next request
// a search re-reads a word after each mismatching bit that moves its candidate
// one request at a time; the result register lets the next request in while a result waits
// reset clears the store (per-word valid bits) and sets bits_in_use to 4096
module bitmap_range_allocator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [bra_pkg::CFG_W-1:0]         cfg_wdata,   // bits_in_use
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // opcode, start_index, run_length, align_log2
    input  logic [bra_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status, found_index, zero pad
    output logic [bra_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int OP_LO    = 0;
    localparam int START_LO = OP_LO + bra_pkg::OP_W;
    localparam int LEN_LO   = START_LO + bra_pkg::START_W;
    localparam int ALOG_LO  = LEN_LO + bra_pkg::LEN_W;
    localparam int PAD_W    = bra_pkg::OUT_DATA_W - bra_pkg::STAT_W - bra_pkg::START_W;

    logic [bra_pkg::CFG_W-1:0]      bits_in_use_reg;
    logic [bra_pkg::WORDS-1:0]      valid_reg;
    logic                           rd_vld_reg;
    logic [bra_pkg::WORD_BITS-1:0]  ram_rdata;
    logic [bra_pkg::WORD_BITS-1:0]  rd_word;
    logic [bra_pkg::STAT_W-1:0]     status;
    logic [bra_pkg::START_W-1:0]    found_index;
    bra_pkg::mem_req_t              mem_req;
    bra_pkg::word_ctl_t             word_ctl;
    bra_pkg::word_res_t             word_res;

    // size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_in_use_reg <= bra_pkg::CFG_W'(bra_pkg::CFG_RESET);
        end
        else if (cfg_wen)
        begin
            bits_in_use_reg <= cfg_wdata;
        end
    end

    // per-word valid bits: an unwritten word reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (mem_req.wr_en)
            begin
                valid_reg[mem_req.addr] <= 1'b1;
            end
            if (mem_req.rd_en)
            begin
                rd_vld_reg <= valid_reg[mem_req.addr];
            end
        end
    end

    assign rd_word = rd_vld_reg ? ram_rdata : '0;

    // bit store
    bra_ram #(
        .WIDTH (bra_pkg::WORD_BITS),
        .DEPTH (bra_pkg::WORDS)
    ) u_store (
        .clk   (clk),
        .we    (mem_req.wr_en),
        .waddr (mem_req.addr),
        .wdata (word_res.wdata),
        .re    (mem_req.rd_en),
        .raddr (mem_req.addr),
        .rdata (ram_rdata)
    );

    // shared word unit
    bra_word_unit u_word (
        .data (rd_word),
        .ctl  (word_ctl),
        .res  (word_res)
    );

    // sequencer
    bra_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_size    (bits_in_use_reg),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .opcode      (s_tdata[OP_LO +: bra_pkg::OP_W]),
        .start_index (s_tdata[START_LO +: bra_pkg::START_W]),
        .run_length  (s_tdata[LEN_LO +: bra_pkg::LEN_W]),
        .align_log2  (s_tdata[ALOG_LO +: bra_pkg::ALOG_W]),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .status      (status),
        .found_index (found_index),
        .mem_req     (mem_req),
        .word_ctl    (word_ctl),
        .word_res    (word_res)
    );

    // result word packing
    assign m_tdata = {{PAD_W{1'b0}}, found_index, status};

endmodule
